// ===== design/sp2a_pkg.sv =====
// Package: types, constants and helpers for the segregated power-of-two block allocator.
package sp2a_pkg;

    localparam int ADDR_W = 18;
    localparam int REQ_W = 16;
    localparam int BYTES_W = 13;
    localparam int STATUS_W = 2;
    localparam int TAG_W = 4;
    localparam int CLASS_W = 3;
    localparam int NUM_CLASSES = 8;
    localparam int GRAN_PER_PAGE = 256;

    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_POOL_PAGES = 64;
    localparam int DEF_HEADER_BYTES = 8;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

    localparam logic [TAG_W-1:0] TAG_NONE = 4'd0;
    localparam logic [TAG_W-1:0] TAG_PAGE = 4'd9;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    typedef struct packed {
        logic kind;
        logic [REQ_W-1:0] request_bytes;
        logic [ADDR_W-1:0] user_address;
    } req_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [BYTES_W-1:0] granted_bytes;
        logic [STATUS_W-1:0] status;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decide;
    } sp2a_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } sp2a_stat_t;

endpackage

// ===== design/sp2a_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
module sp2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/sp2a_ctrl.sv =====
// Controller: sequences clear pass, request load, memory read and decision.
module sp2a_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear_done,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    output sp2a_pkg::sp2a_cmd_t cmd
);
    import sp2a_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic out_free;

    assign out_free = !out_valid || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // decision waits until the result register is free
                if (out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> out_free)
        else $error("decide while result waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("ready during read");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.decide))
        else $error("load and decide together");
endmodule

// ===== design/sp2a_datapath.sv =====
// Datapath: class heads, carve pointers, page counter, link and tag memories.
module sp2a_datapath #(
    parameter int PAGE_BYTES = sp2a_pkg::DEF_PAGE_BYTES,
    parameter int POOL_PAGES = sp2a_pkg::DEF_POOL_PAGES,
    parameter int HEADER_BYTES = sp2a_pkg::DEF_HEADER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sp2a_pkg::sp2a_cmd_t cmd,
    input  sp2a_pkg::req_word_t req,
    output logic                clear_done,
    output logic                out_valid,
    input  logic                out_ready,
    output sp2a_pkg::rsp_word_t rsp
);
    import sp2a_pkg::*;

    localparam int GRAN_BYTES = PAGE_BYTES / 256;
    localparam int GRAN_SH = $clog2(GRAN_BYTES);
    localparam int MAX_PAGES = 262144 / PAGE_BYTES;
    localparam int USABLE = (POOL_PAGES < MAX_PAGES) ? POOL_PAGES : MAX_PAGES;
    localparam int GRANULES = USABLE * GRAN_PER_PAGE;
    localparam int G_W = $clog2(GRANULES + 1);
    localparam int GI_W = (GRANULES > 1) ? $clog2(GRANULES) : 1;
    localparam int PG_W = $clog2(USABLE + 1);
    localparam logic [G_W-1:0] NIL = G_W'(GRANULES);

    logic [G_W-1:0] head_reg [NUM_CLASSES];
    logic [G_W-1:0] carve_reg [NUM_CLASSES];
    logic [PG_W-1:0] pages_reg;
    logic [GI_W:0] clr_reg;
    req_word_t req_reg;
    req_word_t rq;

    // request decode: incoming word during load, registered word afterwards
    logic is_free, a_bad, a_page, f_bad;
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] fg;
    logic [GI_W-1:0] gi;
    logic [REQ_W:0] size;
    logic [REQ_W:0] v;

    assign rq = cmd.load ? req : req_reg;
    assign is_free = (rq.kind == KIND_FREE);
    assign size = {1'b0, rq.request_bytes} + (REQ_W+1)'(HEADER_BYTES);
    assign a_bad = (rq.request_bytes == '0) || (size > (REQ_W+1)'(PAGE_BYTES));
    assign a_page = size > (REQ_W+1)'(PAGE_BYTES / 2);
    assign v = ((size - 1'b1) & (REQ_W+1)'(PAGE_BYTES - 1)) >> GRAN_SH;

    always_comb
    begin
        cls = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (v[i])
            begin
                cls = CLASS_W'(i + 1);
            end
        end
    end

    assign start = rq.user_address - ADDR_W'(HEADER_BYTES);
    assign fg = start >> GRAN_SH;
    assign f_bad = (rq.user_address < ADDR_W'(HEADER_BYTES))
                   || ((start & ADDR_W'(GRAN_BYTES - 1)) != '0)
                   || (fg >= ADDR_W'(GRANULES));
    assign gi = fg[GI_W-1:0];

    // memories
    logic link_we, tag_we;
    logic [GI_W-1:0] link_wa, tag_wa, link_ra, tag_ra;
    logic [G_W-1:0] link_wd, link_rd;
    logic [TAG_W-1:0] tag_wd, tag_rd;

    sp2a_ram #(.WIDTH(G_W), .DEPTH(GRANULES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
        .raddr(link_ra), .rdata(link_rd));
    sp2a_ram #(.WIDTH(TAG_W), .DEPTH(GRANULES)) u_tag (
        .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .raddr(tag_ra), .rdata(tag_rd));

    // read addresses issued in the load cycle, data ready for the decision
    logic [G_W-1:0] hsel;
    assign hsel = head_reg[cls];
    assign link_ra = hsel[GI_W-1:0];
    assign tag_ra = gi;
    assign clear_done = clr_reg[GI_W];

    // decision
    logic [G_W-1:0] g;
    logic ok, use_head, use_carve, use_page;
    logic [G_W-1:0] step, cnext, pbase;
    logic [BYTES_W-1:0] need;
    logic [STATUS_W-1:0] st;
    logic tag_small;

    assign step = G_W'(1) << cls;
    assign pbase = G_W'(pages_reg) << 8;
    assign use_head = hsel != NIL;
    assign use_carve = !use_head && (carve_reg[cls] != NIL);
    assign use_page = pages_reg < PG_W'(USABLE);
    assign tag_small = (tag_rd != TAG_NONE) && (tag_rd < TAG_PAGE);
    assign need = BYTES_W'(GRAN_BYTES << cls);

    always_comb
    begin
        g = '0;
        ok = 1'b0;
        st = ST_OK;
        cnext = NIL;
        if (is_free)
        begin
            if (rq.user_address == '0)
            begin
                st = ST_OK;
            end
            else if (f_bad || !tag_small)
            begin
                st = ST_BADFREE;
            end
            else
            begin
                ok = 1'b1;
            end
        end
        else if (a_bad)
        begin
            st = ST_BADSIZE;
        end
        else if (a_page)
        begin
            if (use_page)
            begin
                ok = 1'b1;
                g = pbase;
            end
            else
            begin
                st = ST_EXHAUSTED;
            end
        end
        else if (use_head)
        begin
            ok = 1'b1;
            g = hsel;
        end
        else if (use_carve)
        begin
            ok = 1'b1;
            g = carve_reg[cls];
            cnext = (((g + step) & G_W'(GRAN_PER_PAGE - 1)) == '0) ? NIL : g + step;
        end
        else if (use_page)
        begin
            ok = 1'b1;
            g = pbase;
            cnext = (step < G_W'(GRAN_PER_PAGE)) ? g + step : NIL;
        end
        else
        begin
            st = ST_EXHAUSTED;
        end
    end

    logic [CLASS_W-1:0] fcls;
    assign fcls = CLASS_W'(tag_rd - 1'b1);

    always_comb
    begin
        link_we = 1'b0;
        link_wa = gi;
        link_wd = head_reg[fcls];
        tag_we = 1'b0;
        tag_wa = gi;
        tag_wd = TAG_NONE;
        if (!clear_done)
        begin
            tag_we = 1'b1;
            tag_wa = clr_reg[GI_W-1:0];
        end
        else if (cmd.decide && ok)
        begin
            if (is_free)
            begin
                link_we = 1'b1;
                tag_we = 1'b1;
            end
            else
            begin
                tag_we = 1'b1;
                tag_wa = g[GI_W-1:0];
                tag_wd = a_page ? TAG_PAGE : TAG_W'(cls) + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= NIL;
                carve_reg[i] <= NIL;
            end
            pages_reg <= '0;
            clr_reg <= '0;
            out_valid <= 1'b0;
            rsp <= '0;
        end
        else
        begin
            if (!clear_done)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_valid && out_ready && !cmd.decide)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.decide)
            begin
                out_valid <= 1'b1;
                rsp.status <= st;
                rsp.granted_address <= (ok && !is_free)
                    ? ADDR_W'((ADDR_W'(g) << GRAN_SH) + ADDR_W'(HEADER_BYTES)) : '0;
                rsp.granted_bytes <= (ok && !is_free)
                    ? (a_page ? BYTES_W'(PAGE_BYTES) : need) : '0;
                if (ok)
                begin
                    if (is_free)
                    begin
                        head_reg[fcls] <= G_W'(gi);
                    end
                    else if (a_page)
                    begin
                        pages_reg <= pages_reg + 1'b1;
                    end
                    else if (use_head)
                    begin
                        head_reg[cls] <= link_rd;
                    end
                    else
                    begin
                        carve_reg[cls] <= cnext;
                        if (!use_carve)
                        begin
                            pages_reg <= pages_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> clear_done)
        else $error("request during clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        pages_reg <= PG_W'(USABLE))
        else $error("page count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && is_free |=> rsp.granted_address == '0)
        else $error("free returned address");
endmodule

// ===== design/segregated_pow2_block_allocator_core.sv =====
// Top level: segregated power-of-two block allocator.
// Flow: an accepted request word is loaded and the tag/link memories are read, then the decision
// writes the result word once the result register is free; the next request is taken only after that.
// Result register lets the next request load while a result waits.
// Reset: lists null, carve pointers exhausted, no pages used; then a tag clearing
// pass over every granule (16384 at defaults) before the first request is taken.
module segregated_pow2_block_allocator_core #(
    parameter int PAGE_BYTES = sp2a_pkg::DEF_PAGE_BYTES,
    parameter int POOL_PAGES = sp2a_pkg::DEF_POOL_PAGES,
    parameter int HEADER_BYTES = sp2a_pkg::DEF_HEADER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sp2a_pkg::req_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sp2a_pkg::rsp_word_t out_data
);
    import sp2a_pkg::*;

    sp2a_cmd_t cmd;
    logic clear_done;

    sp2a_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .clear_done(clear_done),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd));

    sp2a_datapath #(
        .PAGE_BYTES(PAGE_BYTES), .POOL_PAGES(POOL_PAGES), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(in_data),
        .clear_done(clear_done), .out_valid(out_valid), .out_ready(out_ready),
        .rsp(out_data));
endmodule

// ===== sim/segregated_pow2_block_allocator_core_tb.sv =====
// Testbench for the segregated power-of-two block allocator: directed and random traffic.
module segregated_pow2_block_allocator_core_tb;
    import sp2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE = DEF_PAGE_BYTES;
    localparam int HDR = DEF_HEADER_BYTES;
    localparam int GRAN = PAGE / 256;
    localparam int PAGES = DEF_POOL_PAGES;
    localparam int NGRAN = PAGES * GRAN_PER_PAGE;
    localparam int NIL = NGRAN;
    localparam int LIMIT = 400000;

    class alloc_scoreboard;
        int free_head [NUM_CLASSES];
        int carve_next [NUM_CLASSES];
        int next_link [NGRAN];
        int class_tag [NGRAN];
        int pages_used;
        rsp_word_t pending [$];
        int errors;
        int checked;
        int live [$];

        function void clear();
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                free_head[i] = NIL;
                carve_next[i] = NIL;
            end
            for (int i = 0; i < NGRAN; i++)
            begin
                next_link[i] = 0;
                class_tag[i] = 0;
            end
            pages_used = 0;
            errors = 0;
            checked = 0;
        endfunction

        function rsp_word_t make(int a, int b, logic [STATUS_W-1:0] s);
            rsp_word_t r;
            r.granted_address = ADDR_W'(a);
            r.granted_bytes = BYTES_W'(b);
            r.status = s;
            return r;
        endfunction

        function rsp_word_t predict_free(int addr);
            int start;
            int g;
            int t;
            if (addr == 0)
                return make(0, 0, ST_OK);
            if (addr < HDR)
                return make(0, 0, ST_BADFREE);
            start = addr - HDR;
            g = start / GRAN;
            if (start % GRAN != 0 || g >= NGRAN)
                return make(0, 0, ST_BADFREE);
            t = class_tag[g];
            if (t == 0 || t > NUM_CLASSES)
                return make(0, 0, ST_BADFREE);
            next_link[g] = free_head[t-1];
            free_head[t-1] = g;
            class_tag[g] = 0;
            return make(0, 0, ST_OK);
        endfunction

        function rsp_word_t predict_alloc(int req);
            int size;
            int cls;
            int v;
            int step;
            int g;
            if (req == 0)
                return make(0, 0, ST_BADSIZE);
            size = req + HDR;
            if (size > PAGE)
                return make(0, 0, ST_BADSIZE);
            if (size > PAGE / 2)
            begin
                if (pages_used >= PAGES)
                    return make(0, 0, ST_EXHAUSTED);
                g = pages_used * GRAN_PER_PAGE;
                pages_used++;
                class_tag[g] = TAG_PAGE;
                live.push_back(g * GRAN + HDR);
                return make(g * GRAN + HDR, PAGE, ST_OK);
            end
            v = ((size - 1) & (PAGE - 1)) / GRAN;
            cls = 0;
            while (v != 0)
            begin
                v = v >> 1;
                cls++;
            end
            cls = cls & (NUM_CLASSES - 1);
            step = 1 << cls;
            if (free_head[cls] < NIL)
            begin
                g = free_head[cls];
                free_head[cls] = next_link[g];
            end
            else if (carve_next[cls] < NIL)
            begin
                g = carve_next[cls];
                carve_next[cls] = ((g + step) % GRAN_PER_PAGE == 0) ? NIL : g + step;
            end
            else if (pages_used < PAGES)
            begin
                g = pages_used * GRAN_PER_PAGE;
                pages_used++;
                carve_next[cls] = (step < GRAN_PER_PAGE) ? g + step : NIL;
            end
            else
                return make(0, 0, ST_EXHAUSTED);
            class_tag[g] = cls + 1;
            live.push_back(g * GRAN + HDR);
            return make(g * GRAN + HDR, GRAN << cls, ST_OK);
        endfunction

        function void note_request(req_word_t w);
            if (w.kind == KIND_FREE)
                pending.push_back(predict_free(w.user_address));
            else
                pending.push_back(predict_alloc(w.request_bytes));
        endfunction

        function void check_result(rsp_word_t r);
            rsp_word_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.granted_address !== r.granted_address)
            begin
                $display("%0t: address expected %0d actual %0d", $time,
                         e.granted_address, r.granted_address);
                errors++;
            end
            if (e.granted_bytes !== r.granted_bytes)
            begin
                $display("%0t: bytes expected %0d actual %0d", $time,
                         e.granted_bytes, r.granted_bytes);
                errors++;
            end
            if (e.status !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_word_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_word_t out_data;

    alloc_scoreboard sb;
    int cycles;
    int sent;
    bit hold_off;

    segregated_pow2_block_allocator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 3) != 0) || (cycles % 400 < 100);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);

    task automatic send_word(logic k, int req, int addr);
        req_word_t w;
        w.kind = k;
        w.request_bytes = REQ_W'(req);
        w.user_address = ADDR_W'(addr);
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(w);
        sent++;
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_alloc(int req);
        send_word(KIND_ALLOC, req, $urandom_range(0, 262143));
        maybe_gap();
    endtask

    task automatic send_free(int addr);
        send_word(KIND_FREE, $urandom_range(0, 65535), addr);
        maybe_gap();
    endtask

    task automatic free_live();
        int i;
        int a;
        if (sb.live.size() == 0)
        begin
            send_free(0);
            return;
        end
        i = $urandom_range(0, sb.live.size() - 1);
        a = sb.live[i];
        sb.live.delete(i);
        send_free(a);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_alloc($urandom_range(1, 2040));
        else if (r < 45)
            send_alloc($urandom_range(2041, 4088));
        else if (r < 48)
            send_alloc($urandom_range(0, 65535));
        else if (r < 85)
            free_live();
        else if (r < 92)
            send_free($urandom_range(0, 262143));
        else if (r < 96)
            send_free(($urandom_range(0, NGRAN - 1) * GRAN) + HDR);
        else
            send_free(0);
    endtask

    initial
    begin
        int total;
        sb = new();
        sb.clear();
        sent = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_alloc(0);
        send_alloc(65535);
        send_alloc(4089);
        send_alloc(4088);
        send_alloc(2041);
        send_alloc(1);
        send_alloc(8);
        send_alloc(9);
        for (int c = 1; c < NUM_CLASSES; c++)
            send_alloc((GRAN << c) - HDR);
        send_free(0);
        send_free(7);
        send_free(HDR + 1);
        send_free(262143);
        send_free(PAGE * 50 + HDR);
        send_free(HDR);
        free_live();
        free_live();
        send_alloc(2040);

        // long hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (30) random_item();
        join

        total = 550;
        while (sent < total)
        begin
            random_item();
            // drain the pool now and then to reach exhaustion
            if (sent % 150 == 0)
                repeat (70) send_alloc($urandom_range(2041, 4088));
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Covered %0d requests and %0d results: classes, whole pages, bad sizes,",
                 sent, sb.checked);
        $display("invalid and null frees, list reuse and pool exhaustion.");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
